// File: design/ssstat_pkg.sv
// ----------------------------------------------------------------------------
// ssstat_pkg
// Shared types and constants for the sample set statistics block.
// ----------------------------------------------------------------------------
package ssstat_pkg;

   localparam int MAX_SAMPLES = 65536;   // largest set; a set holds 1 .. 65536 words
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 17;
   localparam int SUM_W       = 33;
   localparam int SUMSQ_W     = 47;
   localparam int VAR_W       = 31;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SAMPLES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one finished set, as handed from the accumulator to the finalizer
   typedef struct packed {
      logic signed [SUM_W-1:0]    sum;
      logic        [SUMSQ_W-1:0]  sumsq;
      logic signed [SAMPLE_W-1:0] min_val;
      logic signed [SAMPLE_W-1:0] max_val;
      logic        [COUNT_W-1:0]  count;
      logic                       dropped;
   } set_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV_MEAN,
      BK_DIV_VAR,
      BK_DONE
   } back_state_type;

endpackage

// File: design/ssstat_front.sv
// ----------------------------------------------------------------------------
// ssstat_front
// Accumulates sum, sum of squares, min, max and count, one word per cycle
// while accept is high; pushes the finished set record on the last word.
// ----------------------------------------------------------------------------
module ssstat_front
   import ssstat_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       last,
   output logic                       push,
   output set_rec_type                push_rec
);

   logic signed [SUM_W-1:0]    sum_ff,   sum_in;
   logic        [SUMSQ_W-1:0]  sumsq_ff, sumsq_in;
   logic signed [SAMPLE_W-1:0] min_ff,   min_in;
   logic signed [SAMPLE_W-1:0] max_ff,   max_in;
   logic        [COUNT_W-1:0]  count_ff, count_in;
   logic                       drop_ff,  drop_in;

   logic        [2*SAMPLE_W-1:0] square;
   set_rec_type                  nxt;

   // operands widened first so the product keeps all 31 magnitude bits
   assign square = 32'(sample) * 32'(sample);

   always_comb begin
      nxt.sum     = sum_ff;
      nxt.sumsq   = sumsq_ff;
      nxt.min_val = min_ff;
      nxt.max_val = max_ff;
      nxt.count   = count_ff;
      nxt.dropped = drop_ff;
      if (count_ff < MAX_COUNT) begin
         nxt.sum     = sum_ff + SUM_W'(sample);
         nxt.sumsq   = sumsq_ff + SUMSQ_W'(square);
         nxt.min_val = (sample < min_ff) ? sample : min_ff;
         nxt.max_val = (sample > max_ff) ? sample : max_ff;
         nxt.count   = count_ff + COUNT_W'(1);
      end else begin
         nxt.dropped = 1'b1;
      end

      push     = accept && last;
      push_rec = nxt;

      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            sumsq_in = '0;
            min_in   = 16'sh7fff;
            max_in   = 16'sh8000;
            count_in = '0;
            drop_in  = 1'b0;
         end else begin
            sum_in   = nxt.sum;
            sumsq_in = nxt.sumsq;
            min_in   = nxt.min_val;
            max_in   = nxt.max_val;
            count_in = nxt.count;
            drop_in  = nxt.dropped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
         min_ff   <= 16'sh7fff;
         max_ff   <= 16'sh8000;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// File: design/ssstat_queue.sv
// ----------------------------------------------------------------------------
// ssstat_queue
// Short queue of finished set records between accumulator and finalizer.
// ----------------------------------------------------------------------------
module ssstat_queue
   import ssstat_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  set_rec_type      push_rec,
   input  logic             pop,
   output set_rec_type      head_rec,
   output queue_status_type status
);

   set_rec_type        mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    fill_ff,   fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
      status.full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      status.empty = (fill_ff == '0);
      head_rec     = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: design/ssstat_back.sv
// ----------------------------------------------------------------------------
// ssstat_back
// Finalizer: one shared 32x32 multiplier builds n*sumsq - sum^2 and n^2,
// one radix-2 divider gives the mean and the variance, then the result
// word is held in the output register.
// ----------------------------------------------------------------------------
module ssstat_back
   import ssstat_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  set_rec_type                head_rec,
   input  queue_status_type           q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_mean,
   output logic signed [SAMPLE_W-1:0] rsp_minimum,
   output logic signed [SAMPLE_W-1:0] rsp_maximum,
   output logic        [VAR_W-1:0]    rsp_variance,
   output logic        [COUNT_W-1:0]  rsp_sample_count,
   output logic                       rsp_overflow
);

   back_state_type state_ff, state_in;

   set_rec_type          rec_ff,   rec_in;
   logic [31:0]          abs_ff,   abs_in;
   logic [2:0]           step_ff,  step_in;
   logic [63:0]          prod_ff,  prod_in;
   logic [63:0]          acc_ff,   acc_in;
   logic [32:0]          nsq_ff,   nsq_in;
   logic [32:0]          dvs_ff,   dvs_in;
   logic [32:0]          rem_ff,   rem_in;
   logic [63:0]          quo_ff,   quo_in;
   logic [5:0]           cnt_ff,   cnt_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;

   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_mean_ff,  out_mean_in;
   logic signed [SAMPLE_W-1:0] out_min_ff,   out_min_in;
   logic signed [SAMPLE_W-1:0] out_max_ff,   out_max_in;
   logic        [VAR_W-1:0]    out_var_ff,   out_var_in;
   logic        [COUNT_W-1:0]  out_cnt_ff,   out_cnt_in;
   logic                       out_ovf_ff,   out_ovf_in;

   logic [31:0] mul_a, mul_b;
   logic [33:0] trial;
   logic        fits;
   logic [32:0] rem_step;
   logic [63:0] quo_step;
   logic [16:0] mean_mag;
   logic        out_free;

   // shared multiplier operands follow the step
   always_comb begin
      unique case (step_ff)
         3'd0:    begin mul_a = 32'(rec_ff.count); mul_b = 32'(rec_ff.sumsq[23:0]);  end
         3'd1:    begin mul_a = 32'(rec_ff.count); mul_b = 32'(rec_ff.sumsq[46:24]); end
         3'd2:    begin mul_a = abs_ff;            mul_b = abs_ff;                    end
         default: begin mul_a = 32'(rec_ff.count); mul_b = 32'(rec_ff.count);       end
      endcase
   end

   // one restoring divide step
   always_comb begin
      trial    = {rem_ff, quo_ff[63]};
      fits     = (trial >= {1'b0, dvs_ff});
      rem_step = fits ? 33'(trial - {1'b0, dvs_ff}) : trial[32:0];
      quo_step = {quo_ff[62:0], fits};
      mean_mag = quo_step[16:0];
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      rec_in   = rec_ff;
      abs_in   = abs_ff;
      step_in  = step_ff;
      prod_in  = mul_a * mul_b;
      acc_in   = acc_ff;
      nsq_in   = nsq_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      mean_in  = mean_ff;
      pop      = 1'b0;

      out_valid_in = out_valid_ff && rsp_stall;
      out_mean_in  = out_mean_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      out_var_in   = out_var_ff;
      out_cnt_in   = out_cnt_ff;
      out_ovf_in   = out_ovf_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               rec_in   = head_rec;
               abs_in   = head_rec.sum[SUM_W-1] ? 32'(-head_rec.sum) : 32'(head_rec.sum);
               step_in  = 3'd0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd0: ;
               3'd1: acc_in = prod_ff;
               3'd2: acc_in = acc_ff + {prod_ff[39:0], 24'b0};
               3'd3: acc_in = acc_ff - prod_ff;
               default: begin
                  nsq_in   = prod_ff[32:0];
                  dvs_in   = 33'(rec_ff.count);
                  rem_in   = '0;
                  quo_in   = {abs_ff, 32'b0};
                  cnt_in   = 6'd31;
                  state_in = BK_DIV_MEAN;
               end
            endcase
         end
         BK_DIV_MEAN: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               mean_in  = rec_ff.sum[SUM_W-1] ? SAMPLE_W'(-mean_mag) : SAMPLE_W'(mean_mag);
               dvs_in   = nsq_ff;
               rem_in   = '0;
               quo_in   = acc_ff;
               cnt_in   = 6'd63;
               state_in = BK_DIV_VAR;
            end
         end
         BK_DIV_VAR: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_mean_in  = mean_ff;
               out_min_in   = rec_ff.min_val;
               out_max_in   = rec_ff.max_val;
               out_var_in   = quo_ff[VAR_W-1:0];
               out_cnt_in   = rec_ff.count;
               out_ovf_in   = rec_ff.dropped;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      abs_ff      <= abs_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      nsq_ff      <= nsq_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      mean_ff     <= mean_in;
      out_mean_ff <= out_mean_in;
      out_min_ff  <= out_min_in;
      out_max_ff  <= out_max_in;
      out_var_ff  <= out_var_in;
      out_cnt_ff  <= out_cnt_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mean         = out_mean_ff;
   assign rsp_minimum      = out_min_ff;
   assign rsp_maximum      = out_max_ff;
   assign rsp_variance     = out_var_ff;
   assign rsp_sample_count = out_cnt_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

// File: design/sample_set_statistics.sv
// ----------------------------------------------------------------------------
// sample_set_statistics
// Count, min, max, mean and population variance over sets of Q1.15 words.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle unless req_stall is high; the
// accumulator adds, squares and compares each word in the cycle it is
// accepted. The word marked last closes the set and its totals move into
// a two-entry queue. The finalizer loads the record, forms its products
// on the shared 32x32 multiplier, runs 32 divide steps for the mean and
// 64 for the variance and hands the result to the output register. Sets
// that outlast this work never stall while rsp_stall is low; a run of
// shorter sets stalls the input once both queue entries wait. Words past
// 65536 in one set are dropped and reported through rsp_overflow.
module sample_set_statistics
   import ssstat_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_mean,
   output logic signed [SAMPLE_W-1:0] rsp_minimum,
   output logic signed [SAMPLE_W-1:0] rsp_maximum,
   output logic        [VAR_W-1:0]    rsp_variance,
   output logic        [COUNT_W-1:0]  rsp_sample_count,
   output logic                       rsp_overflow
);

   queue_status_type q_status;
   set_rec_type      push_rec;
   set_rec_type      head_rec;
   logic             push;
   logic             pop;
   logic             accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   ssstat_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sample   (req_sample),
      .last     (req_last),
      .push     (push),
      .push_rec (push_rec)
   );

   ssstat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   ssstat_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_rec         (head_rec),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean         (rsp_mean),
      .rsp_minimum      (rsp_minimum),
      .rsp_maximum      (rsp_maximum),
      .rsp_variance     (rsp_variance),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// File: design/ssstat_checker.sv
// ----------------------------------------------------------------------------
// ssstat_checker
// Port-level checks on the result words of sample_set_statistics.
// ----------------------------------------------------------------------------
module ssstat_checker
   import ssstat_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_mean,
   input logic signed [SAMPLE_W-1:0] rsp_minimum,
   input logic signed [SAMPLE_W-1:0] rsp_maximum,
   input logic        [VAR_W-1:0]    rsp_variance,
   input logic        [COUNT_W-1:0]  rsp_sample_count,
   input logic                       rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean) && $stable(rsp_variance)
         && $stable(rsp_sample_count) && $stable(rsp_overflow))
      else $error("result word changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0 && rsp_sample_count <= MAX_COUNT)
      else $error("sample count out of range");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_minimum <= rsp_maximum)
      else $error("minimum above maximum");

   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mean >= rsp_minimum && rsp_mean <= rsp_maximum)
      else $error("mean outside min..max");

   a_var_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_variance <= 31'h4000_0000)
      else $error("variance above full scale");

endmodule

bind sample_set_statistics ssstat_checker u_ssstat_checker (.*);

// File: dv/tb_sample_set_statistics.sv
// ----------------------------------------------------------------------------
// tb_sample_set_statistics
// Self-checking bench for the sample set statistics block.
// ----------------------------------------------------------------------------
// A short table of hand-picked sets runs first. Some of these sets have their
// results typed in: single words at the extremes, a repeated word and
// truncation toward zero. Random sets of mixed length and content follow,
// and a model of the accumulators predicts their results. Both sides of
// the block idle at random.
module tb_sample_set_statistics;
   import ssstat_pkg::*;

   localparam int RANDOM_WORDS = 1300;
   localparam int STUCK_LIMIT  = 5000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean;
      logic signed [SAMPLE_W-1:0] minimum;
      logic signed [SAMPLE_W-1:0] maximum;
      logic        [VAR_W-1:0]    variance;
      logic        [COUNT_W-1:0]  sample_count;
      logic                       overflow;
   } set_stats_type;

   // one table row: the sample is sent reps times, last marks only the final copy
   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      int                         reps;
      logic                       typed;
      set_stats_type              want;
   } dir_row_type;

   localparam int DIR_ROWS = 14;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_mean;
   logic signed [SAMPLE_W-1:0] rsp_minimum;
   logic signed [SAMPLE_W-1:0] rsp_maximum;
   logic        [VAR_W-1:0]    rsp_variance;
   logic        [COUNT_W-1:0]  rsp_sample_count;
   logic                       rsp_overflow;

   // travels with the word in flight; tells the monitor to use a typed result
   logic          word_typed = 1'b0;
   set_stats_type word_want = '0;

   // running totals of the set being received
   logic signed [SUM_W-1:0]    tot_sum;
   logic        [SUMSQ_W-1:0]  tot_sumsq;
   logic signed [SAMPLE_W-1:0] tot_min;
   logic signed [SAMPLE_W-1:0] tot_max;
   logic        [COUNT_W-1:0]  tot_count;
   logic                       tot_dropped;

   set_stats_type pending_stats[$];
   dir_row_type   dir_tab [0:DIR_ROWS-1];

   int          errors = 0;
   int          stuck_cycles = 0;
   int unsigned stall_left = 0;
   bit          in_idle = 1'b0;
   bit          out_idle = 1'b0;

   sample_set_statistics dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean         (rsp_mean),
      .rsp_minimum      (rsp_minimum),
      .rsp_maximum      (rsp_maximum),
      .rsp_variance     (rsp_variance),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_totals();
      tot_sum     = '0;
      tot_sumsq   = '0;
      tot_min     = 16'sh7FFF;
      tot_max     = -16'sh8000;
      tot_count   = '0;
      tot_dropped = 1'b0;
   endtask

   task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
      longint sq;
      sq = longint'(s) * longint'(s);
      if (tot_count < MAX_COUNT) begin
         tot_sum   = tot_sum + SUM_W'(s);
         tot_sumsq = tot_sumsq + sq[SUMSQ_W-1:0];
         if (s < tot_min) tot_min = s;
         if (s > tot_max) tot_max = s;
         tot_count = tot_count + 1'b1;
      end else begin
         tot_dropped = 1'b1;
      end
   endtask

   task automatic close_set(output set_stats_type r);
      longint          sum_l;
      longint          n_l;
      longint unsigned abs_sum;
      longint unsigned num;
      sum_l   = tot_sum;
      n_l     = tot_count;
      abs_sum = (sum_l < 0) ? -sum_l : sum_l;
      num     = longint'(tot_sumsq) * n_l - abs_sum * abs_sum;
      r.mean         = SAMPLE_W'(sum_l / n_l);
      r.minimum      = tot_min;
      r.maximum      = tot_max;
      r.variance     = VAR_W'(num / (n_l * n_l));
      r.sample_count = tot_count;
      r.overflow     = tot_dropped;
      clear_totals();
   endtask

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(bit on);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!on || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int unsigned style);
      int unsigned r;
      r = $urandom_range(0, 5);
      if (style == 3) style = $urandom_range(0, 1);
      case (style)
         0: return SAMPLE_W'($urandom);
         1: begin
            case (r)
               0: return -16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sh0000;
               3: return -16'sh0001;
               4: return 16'sh0001;
               default: return -16'sh7FFF;
            endcase
         end
         default: return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   task automatic check_field(string what, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic l,
                            input logic t, input set_stats_type w);
      int unsigned gap;
      gap = pick_gap(in_idle);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= l;
      word_typed <= t;
      word_want  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   always @(negedge clock) begin
      int unsigned n;
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         n = pick_gap(out_idle);
         rsp_stall  <= (n != 0);
         stall_left = (n == 0) ? 0 : n - 1;
      end
   end

   // monitor: predict on every accepted word, check every accepted result
   always @(posedge clock) begin
      set_stats_type due;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            take_sample(req_sample);
            if (req_last) begin
               close_set(due);
               pending_stats.push_back(word_typed ? word_want : due);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_stats.size() == 0) begin
               errors++;
               $display("%0t result: expected none, got mean %0d count %0d",
                        $time, rsp_mean, rsp_sample_count);
            end else begin
               due = pending_stats.pop_front();
               check_field("mean", due.mean, rsp_mean);
               check_field("minimum", due.minimum, rsp_minimum);
               check_field("maximum", due.maximum, rsp_maximum);
               check_field("variance", due.variance, rsp_variance);
               check_field("sample_count", due.sample_count, rsp_sample_count);
               check_field("overflow", due.overflow, rsp_overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int          i;
      int          k;
      int          made;
      int unsigned r;
      int unsigned len;
      int unsigned style;
      clear_totals();

      dir_tab[0]  = '{16'sh7FFF, 1'b1, 1, 1'b1,
                      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 31'd0, 17'd1, 1'b0}};
      dir_tab[1]  = '{-16'sh8000, 1'b1, 1, 1'b1,
                      '{-16'sh8000, -16'sh8000, -16'sh8000, 31'd0, 17'd1, 1'b0}};
      dir_tab[2]  = '{16'sh0000, 1'b1, 1, 1'b1,
                      '{16'sh0000, 16'sh0000, 16'sh0000, 31'd0, 17'd1, 1'b0}};
      dir_tab[3]  = '{-16'sh0001, 1'b1, 1, 1'b1,
                      '{-16'sh0001, -16'sh0001, -16'sh0001, 31'd0, 17'd1, 1'b0}};
      dir_tab[4]  = '{-16'sh8000, 1'b0, 1, 1'b0, '0};
      dir_tab[5]  = '{16'sh7FFF, 1'b1, 1, 1'b0, '0};
      // mean of -7 and 2 truncates toward zero
      dir_tab[6]  = '{-16'sh0007, 1'b0, 1, 1'b0, '0};
      dir_tab[7]  = '{16'sh0002, 1'b1, 1, 1'b1,
                      '{-16'sh0002, -16'sh0007, 16'sh0002, 31'd20, 17'd2, 1'b0}};
      dir_tab[8]  = '{16'sh0001, 1'b1, 3, 1'b1,
                      '{16'sh0001, 16'sh0001, 16'sh0001, 31'd0, 17'd3, 1'b0}};
      dir_tab[9]  = '{-16'sh8000, 1'b0, 1, 1'b0, '0};
      dir_tab[10] = '{16'sh7FFF, 1'b0, 1, 1'b0, '0};
      dir_tab[11] = '{-16'sh8000, 1'b0, 1, 1'b0, '0};
      dir_tab[12] = '{16'sh7FFF, 1'b1, 1, 1'b0, '0};
      dir_tab[13] = '{16'sh1234, 1'b1, 1, 1'b0, '0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      out_idle = 1'b1;
      for (i = 0; i < DIR_ROWS; i++) begin
         in_idle = (dir_tab[i].reps < 100);
         for (k = 0; k < dir_tab[i].reps; k++)
            send_word(dir_tab[i].sample, dir_tab[i].last && (k == dir_tab[i].reps - 1),
                      dir_tab[i].typed, dir_tab[i].want);
      end

      made = 0;
      while (made < RANDOM_WORDS) begin
         in_idle  = ($urandom_range(0, 3) != 0);
         out_idle = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 50)      len = $urandom_range(1, 4);
         else if (r < 85) len = $urandom_range(5, 30);
         else             len = $urandom_range(31, 250);
         style = $urandom_range(0, 3);
         for (k = 0; k < len; k++) begin
            send_word(pick_sample(style), k == len - 1, 1'b0, '0);
            made++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
